>>> hdl/pot_frame_averager_with_reject_core_assert.svh
// Assertion macros shared by the averager RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POT_FRAME_AVERAGER_WITH_REJECT_CORE_ASSERT_SVH
`define POT_FRAME_AVERAGER_WITH_REJECT_CORE_ASSERT_SVH

// Same-cycle implication
`define PFAR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PFAR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pfar_pkg.sv
`timescale 1ns / 1ps

package pfar_pkg;

    // Field widths
    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 10;
    localparam int VAL_W    = 8;
    localparam int ACC_W    = 16;

    // Defaults for top-level parameters
    localparam int CHANNELS_DEF = 16;
    localparam int AVG_LEN_DEF  = 8;

    // Threshold after reset
    localparam logic [VAL_W-1:0] THRESH_RESET = 8'd32;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic [VAL_W-1:0]    write_value;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             frame_done;
        logic             changed;
    } rsp_t;

    // One memory word per channel
    typedef struct packed {
        logic [VAL_W-1:0] stored;
        logic [ACC_W-1:0] acc;
    } entry_t;

    // Update result handed back to the top level
    typedef struct packed {
        logic   we;
        entry_t wdata;
        rsp_t   rsp;
    } upd_t;

endpackage

>>> hdl/pfar_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel with a typed payload
interface pfar_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pfar_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module pfar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pfar_update.sv
`timescale 1ns / 1ps

// Per-item modify step and frame sequencing
module pfar_update #(
    parameter int CHANNELS = 16,
    parameter int AVG_LEN  = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  pfar_pkg::req_t           item,
    input  logic                     present,
    input  pfar_pkg::entry_t         cur,
    input  logic [pfar_pkg::VAL_W-1:0] threshold,
    output pfar_pkg::upd_t           upd
);
    import pfar_pkg::*;

    localparam int FCW    = $clog2(AVG_LEN + 1);
    localparam int AVG_SH = ACC_W + $clog2(AVG_LEN);
    localparam int MUL_W  = ACC_W + 1;
    localparam longint unsigned AVG_MUL =
        ((64'd1 << AVG_SH) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);
    localparam logic [MUL_W-1:0]  AVG_MUL_V = MUL_W'(AVG_MUL);
    localparam logic [FCW-1:0]    FC_LAST   = FCW'(AVG_LEN);
    localparam logic [CH_W-1:0]   LAST_CH   = CH_W'((CHANNELS < 16 ? CHANNELS : 16) - 1);

    logic [FCW-1:0]         frame_cnt_reg, frame_cnt_next;
    logic                   seen_reg, seen_next;

    logic [VAL_W-1:0]       reading;
    logic [VAL_W-1:0]       gap;
    logic [VAL_W-1:0]       add_val;
    logic [ACC_W-1:0]       acc_sum;
    logic [ACC_W+MUL_W-1:0] prod;
    logic [ACC_W-1:0]       q_full;
    logic [VAL_W-1:0]       avg;
    logic                   chg_now;

    // Reduce reading, reject outliers, accumulate
    always_comb
    begin
        reading = item.sample[SAMPLE_W-1:SAMPLE_W-VAL_W];
        gap     = (cur.stored > reading) ? (cur.stored - reading) : (reading - cur.stored);
        add_val = (gap > threshold) ? cur.stored : reading;
        acc_sum = cur.acc + {{(ACC_W-VAL_W){1'b0}}, add_val};
    end

    // Average by reciprocal multiply, exact for a 16-bit dividend
    always_comb
    begin
        prod   = {{MUL_W{1'b0}}, acc_sum} * {{ACC_W{1'b0}}, AVG_MUL_V};
        q_full = ACC_W'(prod >> AVG_SH);
        avg    = (|q_full[ACC_W-1:VAL_W]) ? {VAL_W{1'b1}} : q_full[VAL_W-1:0];
    end

    // Command decode
    always_comb
    begin
        upd            = '0;
        upd.wdata      = cur;
        chg_now        = 1'b0;
        frame_cnt_next = frame_cnt_reg;
        seen_next      = seen_reg;
        unique case (item.cmd)
            CMD_SAMPLE:
            begin
                if (present)
                begin
                    upd.we = 1'b1;
                    if (frame_cnt_reg == '0)
                    begin
                        upd.wdata.acc = '0;
                    end
                    else
                    begin
                        upd.wdata.acc = acc_sum;
                        if (frame_cnt_reg == FC_LAST)
                        begin
                            upd.wdata.stored = avg;
                            chg_now          = (avg != cur.stored);
                        end
                    end
                    if (item.channel == LAST_CH)
                    begin
                        if (frame_cnt_reg >= FC_LAST)
                        begin
                            upd.rsp.frame_done = 1'b1;
                            upd.rsp.changed    = seen_reg | chg_now;
                            frame_cnt_next     = '0;
                            seen_next          = 1'b0;
                        end
                        else
                        begin
                            frame_cnt_next = frame_cnt_reg + 1'b1;
                            seen_next      = seen_reg | chg_now;
                        end
                    end
                    else
                    begin
                        seen_next = seen_reg | chg_now;
                    end
                end
            end
            CMD_WRITE:
            begin
                if (present)
                begin
                    upd.we           = 1'b1;
                    upd.wdata.stored = item.write_value;
                end
            end
            CMD_RESTART:
            begin
                frame_cnt_next = '0;
                seen_next      = 1'b0;
            end
            CMD_READ:
            begin
            end
        endcase
        upd.rsp.value = present ? upd.wdata.stored : '0;
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (fire)
        begin
            frame_cnt_reg <= frame_cnt_next;
            seen_reg      <= seen_next;
        end
    end

`include "pot_frame_averager_with_reject_core_assert.svh"

    `PFAR_ASSERT_IMP(a_cnt_range, 1'b1, frame_cnt_reg <= FC_LAST, "frame count out of range")
    `PFAR_ASSERT_NXT(a_done_clears, fire && upd.rsp.frame_done, frame_cnt_reg == '0 && !seen_reg, "frame not restarted after done")
    `PFAR_ASSERT_IMP(a_done_sample, upd.rsp.frame_done, item.cmd == CMD_SAMPLE && present, "frame done without sample")

endmodule

>>> hdl/pot_frame_averager_with_reject_core.sv
`timescale 1ns / 1ps

// Channel  Dir   Payload                                   Item accepted when
// req      in    cmd, channel, sample, write_value         req.valid && req.ready
// rsp      out   value, frame_done, changed                rsp.valid && rsp.ready
// cfg      in    reject_threshold (8 bits)                 cfg.valid && cfg.ready
//
// One item per cycle unless rsp stalls: the RAM read registers as an item is accepted,
// then modify and write back run in the update stage, whose result registers into rsp.
// A same-channel item right behind another takes the written word from a bypass register.
// Reset clears frame state, per-channel valid bits and sets the threshold to 32.
// rsp stall backs up into the update stage and then req.ready; cfg is always ready.
module pot_frame_averager_with_reject_core #(
    parameter int CHANNELS = pfar_pkg::CHANNELS_DEF,
    parameter int AVG_LEN  = pfar_pkg::AVG_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pfar_stream_if.sink   req,
    pfar_stream_if.source rsp,
    pfar_stream_if.sink   cfg
);
    import pfar_pkg::*;

    localparam int AW = $clog2(CHANNELS);
    localparam int XW = (AW > CH_W) ? AW : CH_W;
    localparam int EW = $bits(entry_t);

    logic [VAL_W-1:0]    thresh_reg;
    logic                s1_valid_reg;
    req_t                s1_item_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_data_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic                byp_valid_reg;
    logic [AW-1:0]       byp_addr_reg;
    entry_t              byp_data_reg;

    logic                in_fire;
    logic                s1_adv;
    logic [XW-1:0]       rd_ch_x;
    logic [XW-1:0]       s1_ch_x;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       s1_addr;
    logic                present;
    logic                ram_we;
    logic [EW-1:0]       ram_rdata;
    entry_t              cur;
    upd_t                upd;

    // Handshakes
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Channel to memory address
    always_comb
    begin
        rd_ch_x = XW'(req.data.channel);
        s1_ch_x = XW'(s1_item_reg.channel);
        raddr   = rd_ch_x[AW-1:0];
        s1_addr = s1_ch_x[AW-1:0];
        present = (32'(s1_item_reg.channel) < CHANNELS);
    end

    // Channel memory: stored value and accumulator
    pfar_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (upd.wdata),
        .re    (in_fire),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Forward the last write, unwritten entries read as zero
    always_comb
    begin
        if (byp_valid_reg && byp_addr_reg == s1_addr)
        begin
            cur = byp_data_reg;
        end
        else if (present && vld_reg[s1_addr])
        begin
            cur = entry_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    pfar_update #(
        .CHANNELS (CHANNELS),
        .AVG_LEN  (AVG_LEN)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_adv),
        .item      (s1_item_reg),
        .present   (present),
        .cur       (cur),
        .threshold (thresh_reg),
        .upd       (upd)
    );

    assign ram_we = s1_adv && upd.we;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                thresh_reg <= cfg.data;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                vld_reg[s1_addr] <= 1'b1;
                byp_valid_reg    <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= req.data;
        end
        if (s1_adv)
        begin
            rsp_data_reg <= upd.rsp;
        end
        if (ram_we)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= upd.wdata;
        end
    end

`include "pot_frame_averager_with_reject_core_assert.svh"

    `PFAR_ASSERT_IMP(a_we_on_adv, ram_we, s1_adv && present, "memory write outside update")
    `PFAR_ASSERT_NXT(a_byp_track, ram_we, byp_valid_reg && byp_addr_reg == $past(s1_addr), "bypass missed write")
    `PFAR_ASSERT_IMP(a_chg_done, rsp_valid_reg && rsp_data_reg.changed, rsp_data_reg.frame_done, "changed without frame done")

endmodule
